// ----- rtl/core/dis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_pkg: shared definitions for the disjoint interval set
// Table sizes, entry layout, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package dis_pkg;

   // table geometry
   localparam int MaxRanges   = 32;
   localparam int ValueWidth  = 16;
   localparam int CountWidth  = $clog2(MaxRanges + 1);
   localparam int AddrWidth   = $clog2(MaxRanges);
   localparam int EntryWidth  = 2 * ValueWidth;

   // stream payload widths
   localparam int StatusWidth  = 3;
   localparam int RspDataWidth = ((2 * ValueWidth + CountWidth + 7) / 8) * 8;
   localparam int ReqDataWidth = ((ValueWidth + 7) / 8) * 8;

   // request kinds
   localparam logic CmdAdd  = 1'b0;
   localparam logic CmdList = 1'b1;

   // result status codes
   typedef logic [StatusWidth-1:0] status_type;
   localparam status_type StMerged   = 3'd0;
   localparam status_type StInserted = 3'd1;
   localparam status_type StFull     = 3'd2;
   localparam status_type StRange    = 3'd3;
   localparam status_type StEmpty    = 3'd4;

   // sequencer states, one-hot
   typedef enum logic [11:0] {
      StIdle    = 12'b0000_0000_0001,
      StScanRd  = 12'b0000_0000_0010,
      StScanChk = 12'b0000_0000_0100,
      StDecide  = 12'b0000_0000_1000,
      StShdRd   = 12'b0000_0001_0000,
      StShdWr   = 12'b0000_0010_0000,
      StShuRd   = 12'b0000_0100_0000,
      StShuWr   = 12'b0000_1000_0000,
      StLstRd   = 12'b0001_0000_0000,
      StLstLd   = 12'b0010_0000_0000,
      StResp    = 12'b0100_0000_0000,
      StSpare   = 12'b1000_0000_0000
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/dis_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; contents not reset.
// ----------------------------------------------------------------------------
module dis_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/disjoint_interval_set.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disjoint_interval_set: sorted table of disjoint, non-adjacent value ranges
// Add requests cover, extend, merge or insert ranges; list requests stream
// every held range in order. Bounds live in one RAM, worked by a sequencer.
// ----------------------------------------------------------------------------
// Flow: an add reads and checks each range scanned, then decides; a merge or insert
//   then reads and writes each entry moved; the result is registered and presented
//   in the response state. At most 32 ranges are scanned or entries moved.
// A list passes through read, load and present states for each range.
// One request at a time; req_tready is high only while the sequencer is idle.
// Reset empties the table (held count to zero); RAM contents are not cleared.
module disjoint_interval_set (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [dis_pkg::ReqDataWidth-1:0] req_tdata,  // [15:0] value
   input  wire logic [0:0]                       req_tuser,  // [0] cmd
   // result channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [15:0] range_low, [31:16] range_high, [37:32] range_count, rest zero
   output logic      [dis_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic      [dis_pkg::StatusWidth-1:0]  rsp_tuser,  // [2:0] status
   output logic                                  rsp_tlast
);

   localparam int VW = dis_pkg::ValueWidth;
   localparam int CW = dis_pkg::CountWidth;
   localparam int AW = dis_pkg::AddrWidth;
   localparam int EW = dis_pkg::EntryWidth;

   dis_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [VW-1:0]      val_ff, val_in;
   logic [EW-1:0]      prev_ff, prev_in;
   logic [EW-1:0]      next_ff, next_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dis_pkg::status_type status_ff, status_in;
   logic [VW-1:0]      lo_ff, lo_in;
   logic [VW-1:0]      hi_ff, hi_in;
   logic               last_ff, last_in;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [EW-1:0]      ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [EW-1:0]      ram_rd_data;

   logic               req_fire;
   logic               rsp_fire;
   logic               has_prev;
   logic               has_next;
   logic               covered;
   logic               left_adj;
   logic               right_adj;
   logic               start_above;

   // bounds memory: start in upper half, end in lower half
   dis_ram #(
      .Width (EW),
      .Depth (dis_pkg::MaxRanges)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // shared compare: scanned start against the request value
   assign start_above = ram_rd_data[EW-1:VW] > val_ff;

   // neighbor tests, widened so the top value never wraps to zero
   assign has_prev  = idx_ff != '0;
   assign has_next  = idx_ff != count_ff;
   assign covered   = has_prev && (prev_ff[VW-1:0] >= val_ff);
   assign left_adj  = has_prev &&
                      (({1'b0, prev_ff[VW-1:0]} + (VW+1)'(1)) == {1'b0, val_ff});
   assign right_adj = has_next &&
                      ({1'b0, next_ff[EW-1:VW]} == ({1'b0, val_ff} + (VW+1)'(1)));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      last_in      = last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = k_ff[AW-1:0];
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = k_ff[AW-1:0];

      case (state_ff)
         dis_pkg::StIdle: begin
            if (req_fire) begin
               val_in = req_tdata[VW-1:0];
               k_in   = '0;
               idx_in = '0;
               if (req_tuser[0] == dis_pkg::CmdList) begin
                  if (count_ff == '0) begin
                     status_in    = dis_pkg::StEmpty;
                     lo_in        = '0;
                     hi_in        = '0;
                     last_in      = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = dis_pkg::StResp;
                  end else begin
                     state_in = dis_pkg::StLstRd;
                  end
               end else if (count_ff == '0) begin
                  state_in = dis_pkg::StDecide;
               end else begin
                  state_in = dis_pkg::StScanRd;
               end
            end
         end

         // scan for the first range starting above the value
         dis_pkg::StScanRd: begin
            state_in = dis_pkg::StScanChk;
         end

         dis_pkg::StScanChk: begin
            if (start_above) begin
               next_in  = ram_rd_data;
               idx_in   = k_ff;
               state_in = dis_pkg::StDecide;
            end else begin
               prev_in = ram_rd_data;
               k_in    = k_ff + CW'(1);
               if ((k_ff + CW'(1)) == count_ff) begin
                  idx_in   = count_ff;
                  state_in = dis_pkg::StDecide;
               end else begin
                  state_in = dis_pkg::StScanRd;
               end
            end
         end

         // pick covered, extend, merge, insert or drop
         dis_pkg::StDecide: begin
            lo_in     = '0;
            hi_in     = '0;
            last_in   = 1'b1;
            status_in = dis_pkg::StMerged;
            if (covered) begin
               rsp_valid_in = 1'b1;
               state_in     = dis_pkg::StResp;
            end else if (left_adj && right_adj) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(idx_ff - CW'(1));
               ram_wr_data = {prev_ff[EW-1:VW], next_ff[VW-1:0]};
               k_in        = idx_ff;
               state_in    = dis_pkg::StShdRd;
            end else if (left_adj) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = AW'(idx_ff - CW'(1));
               ram_wr_data  = {prev_ff[EW-1:VW], val_ff};
               rsp_valid_in = 1'b1;
               state_in     = dis_pkg::StResp;
            end else if (right_adj) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = idx_ff[AW-1:0];
               ram_wr_data  = {val_ff, next_ff[VW-1:0]};
               rsp_valid_in = 1'b1;
               state_in     = dis_pkg::StResp;
            end else if (count_ff == CW'(dis_pkg::MaxRanges)) begin
               status_in    = dis_pkg::StFull;
               rsp_valid_in = 1'b1;
               state_in     = dis_pkg::StResp;
            end else begin
               k_in     = count_ff;
               state_in = dis_pkg::StShuRd;
            end
         end

         // merge: close the gap, moving entries down by one
         dis_pkg::StShdRd: begin
            if ((k_ff + CW'(1)) < count_ff) begin
               ram_rd_addr = AW'(k_ff + CW'(1));
               state_in    = dis_pkg::StShdWr;
            end else begin
               count_in     = count_ff - CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = dis_pkg::StResp;
            end
         end

         dis_pkg::StShdWr: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = k_ff[AW-1:0];
            ram_wr_data = ram_rd_data;
            k_in        = k_ff + CW'(1);
            state_in    = dis_pkg::StShdRd;
         end

         // insert: open a slot, moving entries up by one
         dis_pkg::StShuRd: begin
            if (k_ff > idx_ff) begin
               ram_rd_addr = AW'(k_ff - CW'(1));
               state_in    = dis_pkg::StShuWr;
            end else begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = idx_ff[AW-1:0];
               ram_wr_data  = {val_ff, val_ff};
               count_in     = count_ff + CW'(1);
               status_in    = dis_pkg::StInserted;
               rsp_valid_in = 1'b1;
               state_in     = dis_pkg::StResp;
            end
         end

         dis_pkg::StShuWr: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = k_ff[AW-1:0];
            ram_wr_data = ram_rd_data;
            k_in        = k_ff - CW'(1);
            state_in    = dis_pkg::StShuRd;
         end

         // list: one range per pass
         dis_pkg::StLstRd: begin
            state_in = dis_pkg::StLstLd;
         end

         dis_pkg::StLstLd: begin
            status_in    = dis_pkg::StRange;
            lo_in        = ram_rd_data[EW-1:VW];
            hi_in        = ram_rd_data[VW-1:0];
            last_in      = (k_ff + CW'(1)) == count_ff;
            rsp_valid_in = 1'b1;
            state_in     = dis_pkg::StResp;
         end

         // hold the result until taken
         dis_pkg::StResp: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = dis_pkg::StIdle;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = dis_pkg::StLstRd;
               end
            end
         end

         default: begin
            rsp_valid_in = 1'b0;
            state_in     = dis_pkg::StIdle;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dis_pkg::StIdle;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      prev_ff   <= prev_in;
      next_ff   <= next_in;
      status_ff <= status_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      last_ff   <= last_in;
   end

   // ports
   assign req_tready = state_ff == dis_pkg::StIdle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {(dis_pkg::RspDataWidth - 2 * VW - CW)'(0), count_ff, hi_ff, lo_ff};

   // held count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(dis_pkg::MaxRanges))
      else $error("held count beyond table size");

   // no request is taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted with result pending");

   // held count moves by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CW'(1)) ||
      (count_ff == $past(count_ff) - CW'(1)))
      else $error("held count jumped");

   // an insert always leaves a non-empty table
   a_insert_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == dis_pkg::StInserted)) |-> (count_ff != '0))
      else $error("insert reported with empty table");

   // listed ranges are well formed
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == dis_pkg::StRange)) |-> (lo_ff <= hi_ff))
      else $error("listed range has low above high");

endmodule
`default_nettype wire
